// ===== rtl/core/sql_query_tokenizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// SQL query tokenizer assertion macros
// Shared assertion forms for the tokenizer checker.
// ----------------------------------------------------------------------------
`ifndef SQL_QUERY_TOKENIZER_TOP_MACROS_SVH
`define SQL_QUERY_TOKENIZER_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SQLT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqlt checker: implication failed");

// Condition that must hold on the clock edge after the antecedent.
`define SQLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqlt checker: next-cycle condition failed");

`endif

// ===== rtl/core/sqlt_pkg.sv =====
// ----------------------------------------------------------------------------
// SQL query tokenizer package
// Types, codes and the keyword table shared by the tokenizer files.
// ----------------------------------------------------------------------------
`default_nettype none

package sqlt_pkg;

  localparam int MAX_QUERY_BYTES_DEF = 65536;
  localparam int KEYWORD_CHARS_DEF   = 7;
  localparam int NUM_KEYWORDS        = 17;
  localparam int OFS_W               = 17;

  // Lexer modes.
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WORD  = 3'd1,
    MODE_NUM   = 3'd2,
    MODE_MINUS = 3'd3,
    MODE_STR   = 3'd4,
    MODE_STRQ  = 3'd5,
    MODE_REL   = 3'd6
  } mode_t;

  // Token kinds.
  localparam logic [2:0] KIND_KEYWORD = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_INT     = 3'd2;
  localparam logic [2:0] KIND_STRING  = 3'd3;
  localparam logic [2:0] KIND_SYMBOL  = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  // Error codes.
  localparam logic [1:0] ERR_UNEXPECTED   = 2'd0;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd1;
  localparam logic [1:0] ERR_EXPECT_NE    = 2'd2;

  // Symbol codes.
  localparam logic [3:0] SYM_LPAREN = 4'd0;
  localparam logic [3:0] SYM_RPAREN = 4'd1;
  localparam logic [3:0] SYM_COMMA  = 4'd2;
  localparam logic [3:0] SYM_SEMI   = 4'd3;
  localparam logic [3:0] SYM_STAR   = 4'd4;
  localparam logic [3:0] SYM_EQ     = 4'd5;
  localparam logic [3:0] SYM_LT     = 4'd6;
  localparam logic [3:0] SYM_LE     = 4'd8;

  // Pending relational operator.
  localparam logic [1:0] REL_LT   = 2'd0;
  localparam logic [1:0] REL_GT   = 2'd1;
  localparam logic [1:0] REL_BANG = 2'd2;

  localparam logic [63:0] SAT_MAG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  // One result record.
  typedef struct packed {
    logic [2:0]        token_kind;
    logic [OFS_W-1:0]  start_offset;
    logic [OFS_W-1:0]  end_offset;
    logic [OFS_W-1:0]  content_length;
    logic [4:0]        keyword_index;
    logic [3:0]        symbol_code;
    logic [63:0]       integer_value;
    logic [1:0]        error_code;
    logic [7:0]        offending_byte;
    logic              run_last;
  } tok_rec_t;

  // Keyword text, right-justified, first character in the highest used byte.
  function automatic logic [63:0] kw_text(input logic [4:0] idx);
    logic [63:0] s;
    case (idx)
      5'd0:    s = 64'("CREATE");
      5'd1:    s = 64'("TABLE");
      5'd2:    s = 64'("INT");
      5'd3:    s = 64'("TEXT");
      5'd4:    s = 64'("PRIMARY");
      5'd5:    s = 64'("KEY");
      5'd6:    s = 64'("INSERT");
      5'd7:    s = 64'("INTO");
      5'd8:    s = 64'("VALUES");
      5'd9:    s = 64'("SELECT");
      5'd10:   s = 64'("FROM");
      5'd11:   s = 64'("WHERE");
      5'd12:   s = 64'("AND");
      5'd13:   s = 64'("UPDATE");
      5'd14:   s = 64'("SET");
      5'd15:   s = 64'("DELETE");
      5'd16:   s = 64'("DROP");
      default: s = '0;
    endcase
    return s;
  endfunction

  // Keyword length in characters.
  function automatic logic [3:0] kw_len(input logic [4:0] idx);
    logic [63:0] s;
    logic [3:0]  l;
    s = kw_text(idx);
    l = '0;
    for (int k = 0; k < 8; k++) begin
      if (s[8*k +: 8] != 8'd0) begin
        l = 4'(k + 1);
      end
    end
    return l;
  endfunction

  // Keyword packed with its first character in the lowest byte.
  function automatic logic [63:0] kw_packed(input logic [4:0] idx);
    logic [63:0] s;
    logic [63:0] p;
    logic [3:0]  l;
    s = kw_text(idx);
    l = kw_len(idx);
    p = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < l) begin
        p[8*k +: 8] = s[8*(int'(l) - 1 - k) +: 8];
      end
    end
    return p;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
  endfunction

  // Appends a decimal digit to the magnitude, saturating at 2^63.
  function automatic logic [63:0] add_digit(input logic [63:0] mag, input logic [7:0] c);
    logic [67:0] prod;
    prod = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + {64'd0, c[3:0] - 4'd0};
    return (prod > {4'd0, SAT_MAG}) ? SAT_MAG : prod[63:0];
  endfunction

  // Builds a record from its fields, with run_last cleared.
  function automatic tok_rec_t mk_rec(
    input logic [2:0]       kind,
    input logic [OFS_W-1:0] s,
    input logic [OFS_W-1:0] e,
    input logic [OFS_W-1:0] len,
    input logic [4:0]       kw,
    input logic [3:0]       sym,
    input logic [63:0]      val,
    input logic [1:0]       ecode,
    input logic [7:0]       obyte
  );
    tok_rec_t r;
    r.token_kind     = kind;
    r.start_offset   = s;
    r.end_offset     = e;
    r.content_length = len;
    r.keyword_index  = kw;
    r.symbol_code    = sym;
    r.integer_value  = val;
    r.error_code     = ecode;
    r.offending_byte = obyte;
    r.run_last       = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sql_query_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// SQL query tokenizer
// Results enter the result queue on the byte's transfer; out_ shows its head.
// Throughput: one byte per cycle while out_ready is high and each byte yields
// at most one result; a byte yielding two or three results holds the input
// until the queue (four entries, one read per cycle) has room for three again.
// Reset: synchronous active-low rst_n clears lexer state and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_query_tokenizer_top
  import sqlt_pkg::*;
#(
  parameter int MAX_QUERY_BYTES = MAX_QUERY_BYTES_DEF,
  parameter int KEYWORD_CHARS   = KEYWORD_CHARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_query_byte,
  input  wire logic        in_final_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_token_kind,
  output logic [16:0]      out_start_offset,
  output logic [16:0]      out_end_offset,
  output logic [16:0]      out_content_length,
  output logic [4:0]       out_keyword_index,
  output logic [3:0]       out_symbol_code,
  output logic signed [63:0] out_integer_value,
  output logic [1:0]       out_error_code,
  output logic [7:0]       out_offending_byte,
  output logic             out_run_last
);

  localparam int PW    = $clog2(MAX_QUERY_BYTES + 1);
  localparam int BUF_W = 8 * KEYWORD_CHARS;
  localparam int QD    = 4;
  localparam int QAW   = 2;

  // Lexer state.
  mode_t            mode_r, mode_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [PW-1:0]    tstart_r, tstart_nxt;
  logic [BUF_W-1:0] ubuf_r, ubuf_nxt;
  logic [PW-1:0]    wlen_r, wlen_nxt;
  logic [63:0]      mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic [1:0]       relop_r, relop_nxt;
  logic             errl_r, errl_nxt;

  // Result queue.
  tok_rec_t         q_mem [QD];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r;

  tok_rec_t         rec [3];
  logic [1:0]       n_rec;
  logic             in_xfer, out_xfer;
  logic [63:0]      mag_inc;

  assign in_ready  = (cnt_r <= (QAW+1)'(QD - 3));
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_xfer  = out_valid && out_ready;

  // Magnitude with the incoming digit appended, shared by the NUM and MINUS paths.
  assign mag_inc = add_digit(mag_r, in_query_byte);

  function automatic logic [PW-1:0] inc_sat(input logic [PW-1:0] v);
    return (v < PW'(MAX_QUERY_BYTES)) ? v + 1'b1 : v;
  endfunction

  function automatic logic [16:0] ofs(input logic [PW-1:0] v);
    return 17'(v);
  endfunction

  // Closes a word as keyword or identifier.
  function automatic tok_rec_t word_rec(
    input logic [PW-1:0] s, input logic [PW-1:0] e,
    input logic [PW-1:0] len, input logic [BUF_W-1:0] b
  );
    logic       hit;
    logic [4:0] idx;
    hit = 1'b0;
    idx = '0;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      if ((len == PW'(kw_len(5'(k)))) && (64'(b) == kw_packed(5'(k)))) begin
        hit = 1'b1;
        idx = 5'(k);
      end
    end
    return mk_rec(hit ? KIND_KEYWORD : KIND_IDENT, ofs(s), ofs(e), ofs(len),
                  idx, '0, '0, ERR_UNEXPECTED, 8'd0);
  endfunction

  // Closes an integer, applying sign and saturation.
  function automatic tok_rec_t num_rec(
    input logic [PW-1:0] s, input logic [PW-1:0] e,
    input logic [PW-1:0] len, input logic [63:0] m, input logic ng
  );
    logic [63:0] v;
    v = ng ? (64'd0 - m) : (m[63] ? SAT_POS : m);
    return mk_rec(KIND_INT, ofs(s), ofs(e), ofs(len), '0, '0, v, ERR_UNEXPECTED, 8'd0);
  endfunction

  function automatic tok_rec_t err_rec(
    input logic [PW-1:0] at, input logic [1:0] code, input logic [7:0] ob
  );
    return mk_rec(KIND_ERROR, ofs(at), ofs(at), '0, '0, '0, '0, code, ob);
  endfunction

  // Per-byte lexer step: next state and up to three result records.
  always_comb begin
    logic [7:0] c;
    logic       fin;
    logic       consumed;
    logic       err;
    logic [1:0] n;
    tok_rec_t   r [3];

    c          = in_query_byte;
    fin        = in_final_byte;
    consumed   = 1'b0;
    err        = 1'b0;
    n          = '0;
    for (int i = 0; i < 3; i++) begin
      r[i] = mk_rec(KIND_KEYWORD, '0, '0, '0, '0, '0, '0, ERR_UNEXPECTED, 8'd0);
    end
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    ubuf_nxt   = ubuf_r;
    wlen_nxt   = wlen_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    relop_nxt  = relop_r;
    errl_nxt   = errl_r;

    if (!errl_r) begin
      // Continue the open token.
      case (mode_r)
        MODE_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            for (int b = 0; b < KEYWORD_CHARS; b++) begin
              if (wlen_r == PW'(b)) begin
                ubuf_nxt[8*b +: 8] = to_upper(c);
              end
            end
            wlen_nxt = inc_sat(wlen_r);
            consumed = 1'b1;
          end else begin
            r[n] = word_rec(tstart_r, pos_r, wlen_r, ubuf_r);
            n = n + 2'd1;
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_NUM: begin
          if (is_digit(c)) begin
            mag_nxt  = mag_inc;
            wlen_nxt = inc_sat(wlen_r);
            consumed = 1'b1;
          end else begin
            r[n] = num_rec(tstart_r, pos_r, wlen_r, mag_r, neg_r);
            n = n + 2'd1;
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_MINUS: begin
          if (is_digit(c)) begin
            mag_nxt  = mag_inc;
            wlen_nxt = inc_sat(wlen_r);
            mode_nxt = MODE_NUM;
            consumed = 1'b1;
          end else begin
            r[n] = err_rec(tstart_r, ERR_UNEXPECTED, "-");
            n = n + 2'd1;
            err = 1'b1;
          end
        end
        MODE_STR: begin
          if (c == "'") begin
            mode_nxt = MODE_STRQ;
          end else begin
            wlen_nxt = inc_sat(wlen_r);
          end
          consumed = 1'b1;
        end
        MODE_STRQ: begin
          if (c == "'") begin
            wlen_nxt = inc_sat(wlen_r);
            mode_nxt = MODE_STR;
            consumed = 1'b1;
          end else begin
            r[n] = mk_rec(KIND_STRING, ofs(tstart_r), ofs(pos_r), ofs(wlen_r),
                          '0, '0, '0, ERR_UNEXPECTED, 8'd0);
            n = n + 2'd1;
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_REL: begin
          if (c == "=") begin
            r[n] = mk_rec(KIND_SYMBOL, ofs(tstart_r), ofs(inc_sat(pos_r)), 17'd2,
                          '0, SYM_LE + 4'(relop_r), '0, ERR_UNEXPECTED, 8'd0);
            n = n + 2'd1;
            mode_nxt = MODE_IDLE;
            consumed = 1'b1;
          end else if (relop_r >= REL_BANG) begin
            r[n] = err_rec(tstart_r, ERR_EXPECT_NE, 8'd0);
            n = n + 2'd1;
            err = 1'b1;
          end else begin
            r[n] = mk_rec(KIND_SYMBOL, ofs(tstart_r), ofs(inc_sat(tstart_r)), 17'd1,
                          '0, SYM_LT + 4'(relop_r), '0, ERR_UNEXPECTED, 8'd0);
            n = n + 2'd1;
            mode_nxt = MODE_IDLE;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase

      // Start a new token from this byte.
      if (!consumed && !err && !is_space(c)) begin
        tstart_nxt = pos_r;
        if (is_alpha(c) || c == "_") begin
          mode_nxt = MODE_WORD;
          ubuf_nxt = BUF_W'(to_upper(c));
          wlen_nxt = PW'(1);
        end else if (is_digit(c)) begin
          mode_nxt = MODE_NUM;
          neg_nxt  = 1'b0;
          mag_nxt  = {60'd0, c[3:0]};
          wlen_nxt = PW'(1);
        end else if (c == "-") begin
          mode_nxt = MODE_MINUS;
          neg_nxt  = 1'b1;
          mag_nxt  = '0;
          wlen_nxt = PW'(1);
        end else if (c == "'") begin
          mode_nxt = MODE_STR;
          wlen_nxt = '0;
        end else if (c == "<" || c == ">" || c == "!") begin
          mode_nxt  = MODE_REL;
          relop_nxt = (c == "<") ? REL_LT : (c == ">") ? REL_GT : REL_BANG;
        end else if (c == "(" || c == ")" || c == "," || c == ";" || c == "*" ||
                     c == "=") begin
          r[n] = mk_rec(KIND_SYMBOL, ofs(pos_r), ofs(inc_sat(pos_r)), 17'd1, '0,
                        (c == "(") ? SYM_LPAREN : (c == ")") ? SYM_RPAREN :
                        (c == ",") ? SYM_COMMA  : (c == ";") ? SYM_SEMI :
                        (c == "*") ? SYM_STAR   : SYM_EQ,
                        '0, ERR_UNEXPECTED, 8'd0);
          n = n + 2'd1;
        end else begin
          r[n] = err_rec(pos_r, ERR_UNEXPECTED, c);
          n = n + 2'd1;
          err = 1'b1;
        end
      end

      pos_nxt = inc_sat(pos_r);

      // Close whatever is open at the end of the query, then the end token.
      if (!err && fin) begin
        case (mode_nxt)
          MODE_WORD: begin
            r[n] = word_rec(tstart_nxt, pos_nxt, wlen_nxt, ubuf_nxt);
            n = n + 2'd1;
          end
          MODE_NUM: begin
            r[n] = num_rec(tstart_nxt, pos_nxt, wlen_nxt, mag_nxt, neg_nxt);
            n = n + 2'd1;
          end
          MODE_MINUS: begin
            r[n] = err_rec(tstart_nxt, ERR_UNEXPECTED, "-");
            n = n + 2'd1;
            err = 1'b1;
          end
          MODE_STR: begin
            r[n] = err_rec(tstart_nxt, ERR_UNTERMINATED, 8'd0);
            n = n + 2'd1;
            err = 1'b1;
          end
          MODE_STRQ: begin
            r[n] = mk_rec(KIND_STRING, ofs(tstart_nxt), ofs(pos_nxt), ofs(wlen_nxt),
                          '0, '0, '0, ERR_UNEXPECTED, 8'd0);
            n = n + 2'd1;
          end
          MODE_REL: begin
            if (relop_nxt >= REL_BANG) begin
              r[n] = err_rec(tstart_nxt, ERR_EXPECT_NE, 8'd0);
              n = n + 2'd1;
              err = 1'b1;
            end else begin
              r[n] = mk_rec(KIND_SYMBOL, ofs(tstart_nxt), ofs(inc_sat(tstart_nxt)),
                            17'd1, '0, SYM_LT + 4'(relop_nxt), '0,
                            ERR_UNEXPECTED, 8'd0);
              n = n + 2'd1;
            end
          end
          default: begin
          end
        endcase
        if (!err) begin
          r[n] = mk_rec(KIND_END, ofs(pos_nxt), ofs(pos_nxt), '0, '0, '0, '0,
                        ERR_UNEXPECTED, 8'd0);
          n = n + 2'd1;
        end
      end

      if (!fin && err) begin
        errl_nxt = 1'b1;
      end
    end

    // The final byte always returns the lexer to its reset state.
    if (fin) begin
      mode_nxt   = MODE_IDLE;
      pos_nxt    = '0;
      tstart_nxt = '0;
      ubuf_nxt   = '0;
      wlen_nxt   = '0;
      mag_nxt    = '0;
      neg_nxt    = 1'b0;
      relop_nxt  = REL_LT;
      errl_nxt   = 1'b0;
    end

    // Flag the last result of this byte.
    for (int i = 0; i < 3; i++) begin
      if (2'(i + 1) == n) begin
        r[i].run_last = 1'b1;
      end
    end

    for (int i = 0; i < 3; i++) begin
      rec[i] = r[i];
    end
    n_rec = n;
  end

  // Lexer state registers, updated on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      tstart_r <= '0;
      ubuf_r   <= '0;
      wlen_r   <= '0;
      mag_r    <= '0;
      neg_r    <= 1'b0;
      relop_r  <= REL_LT;
      errl_r   <= 1'b0;
    end else if (in_xfer) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      ubuf_r   <= ubuf_nxt;
      wlen_r   <= wlen_nxt;
      mag_r    <= mag_nxt;
      neg_r    <= neg_nxt;
      relop_r  <= relop_nxt;
      errl_r   <= errl_nxt;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n_rec) begin
          q_mem[wr_ptr_r + QAW'(i)] <= rec[i];
        end
      end
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr_r <= wr_ptr_r + QAW'(n_rec);
      end
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (in_xfer ? (QAW+1)'(n_rec) : '0) - (out_xfer ? (QAW+1)'(1) : '0);
    end
  end

  // Head of the queue drives the result channel.
  assign out_token_kind     = q_mem[rd_ptr_r].token_kind;
  assign out_start_offset   = q_mem[rd_ptr_r].start_offset;
  assign out_end_offset     = q_mem[rd_ptr_r].end_offset;
  assign out_content_length = q_mem[rd_ptr_r].content_length;
  assign out_keyword_index  = q_mem[rd_ptr_r].keyword_index;
  assign out_symbol_code    = q_mem[rd_ptr_r].symbol_code;
  assign out_integer_value  = q_mem[rd_ptr_r].integer_value;
  assign out_error_code     = q_mem[rd_ptr_r].error_code;
  assign out_offending_byte = q_mem[rd_ptr_r].offending_byte;
  assign out_run_last       = q_mem[rd_ptr_r].run_last;

endmodule

`default_nettype wire

// ===== rtl/core/sqlt_checker.sv =====
// ----------------------------------------------------------------------------
// SQL query tokenizer checker
// Port-level checks on the input and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sql_query_tokenizer_top_macros.svh"

module sqlt_checker
  import sqlt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_token_kind,
  input wire logic [16:0] out_start_offset,
  input wire logic [16:0] out_end_offset
);

  // A stalled result stays offered with the same kind.
  `SQLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_token_kind))

  // With nothing queued, an offered byte is always taken.
  `SQLT_ASSERT_IMPL(a_empty_ready, in_valid && !out_valid, in_ready)

  // End tokens and errors span no bytes.
  `SQLT_ASSERT_IMPL(a_end_span, out_valid && out_token_kind == KIND_END, out_start_offset == out_end_offset)
  `SQLT_ASSERT_IMPL(a_err_span, out_valid && out_token_kind == KIND_ERROR, out_start_offset == out_end_offset)

  // Every other token ends at or past where it starts, offsets stay ordered.
  `SQLT_ASSERT_IMPL(a_tok_order, out_valid && out_token_kind != KIND_END && out_token_kind != KIND_ERROR, out_end_offset >= out_start_offset)

endmodule

bind sql_query_tokenizer_top sqlt_checker u_sqlt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_token_kind   (out_token_kind),
  .out_start_offset (out_start_offset),
  .out_end_offset   (out_end_offset)
);

`default_nettype wire
